>>> hw/rtl/girb_pkg.sv
// Shared types, register codes and clip geometry for the gray image rectangle blit.
// No dependencies; used by every module of the block.
package girb_pkg;

  localparam int ADDR_W   = 26;   // frame buffer byte offset
  localparam int POS_W    = 13;   // row and column counters
  localparam int OFS_W    = 14;   // column byte offset within a line
  localparam int LB_W     = 14;   // line_bytes register
  localparam int DIM_W    = 12;   // frame and rectangle dimensions
  localparam int COORD_W  = 16;   // signed device coordinates
  localparam int CFG_AW   = 5;    // APB address bits for eight word registers
  localparam int TDATA_W  = 40;   // byte_addr + byte_data, padded to whole bytes

  localparam logic MODE_PALETTE = 1'b0;
  localparam logic MODE_MONO    = 1'b1;

  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_FRAME_W    = 3'd1,
    REG_FRAME_H    = 3'd2,
    REG_LINE_BYTES = 3'd3,
    REG_LEFT       = 3'd4,
    REG_BOTTOM     = 3'd5,
    REG_WIDTH      = 3'd6,
    REG_HEIGHT     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic               mode;
    logic [DIM_W-1:0]   frame_w;
    logic [DIM_W-1:0]   frame_h;
    logic [LB_W-1:0]    line_bytes;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] bottom;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } cfg_t;

  // Clipped rectangle as the scan needs it
  typedef struct packed {
    logic             mode;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] bottom;
    logic [POS_W-1:0] row_len;
    logic             empty;
  } geom_t;

  // One pending byte write from the scan stage to the address stage
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [OFS_W-1:0] offset;
    logic [7:0]       data;
    logic             last;
  } wr_t;

  // Clamp a signed coordinate to [0, hi]
  function automatic logic [DIM_W-1:0] clamp(input logic signed [17:0] v,
                                             input logic [DIM_W-1:0] hi);
    logic signed [17:0] hs;
    hs = $signed({6'd0, hi});
    if (v < 18'sd0)  return '0;
    else if (v > hs) return hi;
    else             return v[DIM_W-1:0];
  endfunction

  function automatic geom_t calc_geom(input cfg_t c);
    logic signed [17:0] l, r, b, t;
    logic [DIM_W-1:0]   lc, rc, tc, bc, w;
    geom_t              g;
    l  = $signed({{2{c.left[COORD_W-1]}}, c.left});
    b  = $signed({{2{c.bottom[COORD_W-1]}}, c.bottom});
    r  = l + $signed({6'd0, c.width});
    t  = b - $signed({6'd0, c.height});
    lc = clamp(l, c.frame_w);
    rc = clamp(r, c.frame_w);
    tc = clamp(t, c.frame_h);
    bc = clamp(b, c.frame_h);
    w  = rc - lc;
    g.mode    = c.mode;
    g.left    = lc;
    g.top     = tc;
    g.bottom  = bc;
    // one-bit rows take whole bytes
    g.row_len = (c.mode == MODE_MONO) ? (({1'b0, w} + 13'd7) & ~13'd7) : {1'b0, w};
    g.empty   = (w == '0) || (tc >= bc);
    return g;
  endfunction

endpackage

>>> hw/rtl/girb_walk.sv
// Scan stage: row/column walk, bit packing and palette lookup for each pixel item.
// Depends on girb_pkg; feeds the address stage in gray_image_rect_blit.
module girb_walk #(
  parameter int PALETTE_COUNT = 216,
  parameter int PALETTE_BASE  = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           restart,
  input  girb_pkg::cfg_t cfg_nxt,
  input  logic           pix_accept,
  input  logic [7:0]     pixel,
  input  logic           s1_adv,
  output logic           s1_valid,
  output girb_pkg::wr_t  s1
);
  import girb_pkg::*;

  geom_t            geom_r, geom_nxt;
  logic [POS_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [7:0]       acc_r, acc_nxt;
  logic [2:0]       bc_r, bc_nxt;
  logic             done_r, done_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  wr_t              s1_r, s1_nxt;

  logic [7:0]       acc_shift;
  logic [2:0]       bc_inc;
  logic [POS_W-1:0] col_inc, row_inc;
  logic             mono, row_end, emit, fire;
  logic [16:0]      pal_prod;
  logic [7:0]       pal_data;

  assign geom_nxt = calc_geom(cfg_nxt);
  assign mono     = (geom_r.mode == MODE_MONO);

  // Per-pixel arithmetic
  assign acc_shift = {acc_r[6:0], pixel[7]};
  assign bc_inc    = bc_r + 3'd1;
  assign col_inc   = col_r + 13'd1;
  assign row_inc   = row_r + 13'd1;
  assign row_end   = (col_inc >= geom_r.row_len);
  assign emit      = !mono || (bc_inc == 3'd0);
  assign fire      = pix_accept && !done_r && emit;
  assign pal_prod  = {9'd0, pixel} * 17'(PALETTE_COUNT);
  assign pal_data  = pal_prod[15:8] + 8'(PALETTE_BASE);

  // Advance the walk state
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    acc_nxt  = acc_r;
    bc_nxt   = bc_r;
    done_nxt = done_r;
    if (pix_accept && !done_r) begin
      if (mono) begin
        acc_nxt = (bc_inc == 3'd0) ? 8'd0 : acc_shift;
        bc_nxt  = bc_inc;
      end
      col_nxt = col_inc;
      if (row_end) begin
        col_nxt = '0;
        bc_nxt  = '0;
        acc_nxt = '0;
        row_nxt = row_inc;
        if (row_inc >= {1'b0, geom_r.bottom}) begin
          done_nxt = 1'b1;
        end
      end
    end
  end

  // Build the pending write
  always_comb begin
    s1_nxt      = s1_r;
    s1_valid_nxt = s1_adv ? 1'b0 : s1_valid_r;
    if (fire) begin
      s1_valid_nxt = 1'b1;
      s1_nxt.row   = row_r;
      s1_nxt.last  = done_nxt;
      if (mono) begin
        s1_nxt.data   = acc_shift;
        s1_nxt.offset = {5'd0, geom_r.left[DIM_W-1:3]} + {4'd0, col_r[POS_W-1:3]};
      end else begin
        s1_nxt.data   = pal_data;
        s1_nxt.offset = {2'd0, geom_r.left} + {1'b0, col_r};
      end
    end
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
    s1_r   <= s1_nxt;
    if (!rst_n || restart) begin
      row_r  <= {1'b0, geom_nxt.top};
      col_r  <= '0;
      acc_r  <= '0;
      bc_r   <= '0;
      done_r <= geom_nxt.empty;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      acc_r  <= acc_nxt;
      bc_r   <= bc_nxt;
      done_r <= done_nxt;
    end
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

>>> hw/rtl/gray_image_rect_blit.sv
// Top level of the gray image rectangle blit: APB registers, scan stage, address stage.
// Depends on girb_pkg and girb_walk.
//
//   channel  | direction | handshake                 | payload
//   in_      | sink      | in_tvalid / in_tready     | pixel in in_tdata[7:0]
//   out_     | source    | out_tvalid / out_tready   | byte_addr, byte_data; tlast = last
//   cfg_     | APB slave | psel, penable, pready = 1 | eight 32-bit registers at 4*i
//
// One pixel item is taken every cycle while the output is not stalled; a byte passes through
// the scan register, then the row*line_bytes multiply-add into the output register, before
// it leaves. Palette mode gives one byte per pixel, one-bit mode one per eight pixels.
// rst_n clears the configuration registers and restarts the walk at the clipped
// top row; any register write restarts it too. A stalled output holds its byte
// while the scan stage keeps taking pixels until its register is full.
module gray_image_rect_blit #(
  parameter int PALETTE_COUNT = 216,
  parameter int PALETTE_BASE  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,    // [7:0] pixel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [girb_pkg::TDATA_W-1:0]  out_tdata,   // [25:0] byte_addr, [33:26] byte_data
  output logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [girb_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import girb_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  reg_idx_t          reg_idx;
  logic              cfg_wr;

  logic              s1_valid, s1_adv, out_adv;
  wr_t               s1;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        data_r, data_nxt;
  logic              last_r, last_nxt;
  logic [26:0]       line_prod;

  // Register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (!rst_n) begin
      cfg_nxt = '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:       cfg_nxt.mode       = cfg_pwdata[0];
        REG_FRAME_W:    cfg_nxt.frame_w    = cfg_pwdata[DIM_W-1:0];
        REG_FRAME_H:    cfg_nxt.frame_h    = cfg_pwdata[DIM_W-1:0];
        REG_LINE_BYTES: cfg_nxt.line_bytes = cfg_pwdata[LB_W-1:0];
        REG_LEFT:       cfg_nxt.left       = cfg_pwdata[COORD_W-1:0];
        REG_BOTTOM:     cfg_nxt.bottom     = cfg_pwdata[COORD_W-1:0];
        REG_WIDTH:      cfg_nxt.width      = cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT:     cfg_nxt.height     = cfg_pwdata[DIM_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      REG_MODE:       cfg_prdata = {31'd0, cfg_r.mode};
      REG_FRAME_W:    cfg_prdata = {20'd0, cfg_r.frame_w};
      REG_FRAME_H:    cfg_prdata = {20'd0, cfg_r.frame_h};
      REG_LINE_BYTES: cfg_prdata = {18'd0, cfg_r.line_bytes};
      REG_LEFT:       cfg_prdata = {16'd0, cfg_r.left};
      REG_BOTTOM:     cfg_prdata = {16'd0, cfg_r.bottom};
      REG_WIDTH:      cfg_prdata = {20'd0, cfg_r.width};
      REG_HEIGHT:     cfg_prdata = {20'd0, cfg_r.height};
      default:        cfg_prdata = '0;
    endcase
  end

  // Scan stage
  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = out_adv;
  assign in_tready = !s1_valid || out_adv;

  girb_walk #(
    .PALETTE_COUNT (PALETTE_COUNT),
    .PALETTE_BASE  (PALETTE_BASE)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (cfg_wr),
    .cfg_nxt    (cfg_nxt),
    .pix_accept (in_tvalid && in_tready),
    .pixel      (in_tdata),
    .s1_adv     (s1_adv),
    .s1_valid   (s1_valid),
    .s1         (s1)
  );

  // Address stage: row * line_bytes + column offset, wrapped to the address width
  assign line_prod = s1.row * cfg_r.line_bytes;

  always_comb begin
    out_valid_nxt = out_valid_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid;
      addr_nxt      = line_prod[ADDR_W-1:0] + {12'd0, s1.offset};
      data_nxt      = s1.data;
      last_nxt      = s1.last;
    end
  end

  always_ff @(posedge clk) begin
    cfg_r  <= cfg_nxt;
    addr_r <= addr_nxt;
    data_r <= data_nxt;
    last_r <= last_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, data_r, addr_r};
  assign out_tlast  = last_r;

endmodule

>>> hw/rtl/girb_checker.sv
// Port-level checks for gray_image_rect_blit, attached by the bind below.
// Depends on girb_pkg for port widths only.
module girb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [girb_pkg::TDATA_W-1:0] out_tdata,
  input logic                         out_tlast,
  input logic                         cfg_psel,
  input logic                         cfg_penable,
  input logic                         cfg_pwrite,
  input logic                         cfg_pready
);
  logic cfg_wr;
  logic frame_done_r;

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Track a delivered final byte until the next register write
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      frame_done_r <= 1'b0;
    end else if (out_tvalid && out_tready && out_tlast) begin
      frame_done_r <= 1'b1;
    end
  end

  // Stalled output holds its byte
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // Reset empties the output register
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // Nothing follows the final byte of a rectangle until it is restarted
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done_r |-> !out_tvalid)
    else $error("byte emitted after the final byte");

  // Config port never stalls
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready dropped");

endmodule

bind gray_image_rect_blit girb_checker u_girb_checker (.*);

>>> tb/gray_image_rect_blit_test.sv
// Self-checking testbench for gray_image_rect_blit: drives gray pixel items and APB register
// writes, predicts every frame buffer byte write and checks the result stream against it.
// Depends on girb_pkg and the gray_image_rect_blit RTL.
module gray_image_rect_blit_test;
  import girb_pkg::*;

  localparam int PAL_COUNT      = 216;
  localparam int PAL_BASE       = 32;
  localparam int MONO_THRESHOLD = 127;
  localparam int SETTLE_CYCLES  = 8;     // pipeline depth plus margin
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT    = 3000;  // cycles with no handshake before giving up
  localparam int PIXEL_CAP      = 300;   // most pixels sent for one rectangle
  localparam int PHASE_ITEMS    = 267;
  localparam int N_DIR          = 38;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              last;
  } fb_write_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    idx;
    logic [31:0] val;
    logic [7:0]  pix;
    logic        fixed_on;
    fb_write_t   fixed;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = '0;     // [7:0] pixel
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;         // [25:0] byte_addr, [33:26] byte_data
  logic               out_tlast;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]  cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  // Register shadow
  logic               sh_mode;
  logic [DIM_W-1:0]   sh_fw, sh_fh, sh_w, sh_h;
  logic [LB_W-1:0]    sh_lb;
  logic [COORD_W-1:0] sh_left, sh_bottom;

  // Scan position of the predicted walk
  logic [POS_W-1:0]   walk_row, walk_col;
  logic [7:0]         mono_acc;
  logic [2:0]         mono_cnt;
  bit                 walk_done;

  fb_write_t          pending_writes[$];
  fb_write_t          head_write;
  int                 errors = 0;
  int                 quiet_cycles = 0;
  int                 snd_idle_pct = 0;
  int                 rcv_idle_pct = 0;
  bit                 hold_req = 1'b0;
  bit                 hold_taken = 1'b0;
  int                 hold_left = 0;
  stim_row_t          dir_rows [N_DIR];

  gray_image_rect_blit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int clip_to(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Clipped left column, top row, bottom row and width of the rectangle
  function automatic void clip_rect(output int l, output int t, output int b, output int w);
    int r;
    l = int'($signed(sh_left));
    r = l + int'(sh_w);
    b = int'($signed(sh_bottom));
    t = b - int'(sh_h);
    l = clip_to(l, int'(sh_fw));
    r = clip_to(r, int'(sh_fw));
    t = clip_to(t, int'(sh_fh));
    b = clip_to(b, int'(sh_fh));
    w = r - l;
  endfunction

  function automatic void restart_walk();
    int l, t, b, w;
    clip_rect(l, t, b, w);
    walk_row  = POS_W'(t);
    walk_col  = '0;
    mono_acc  = '0;
    mono_cnt  = '0;
    walk_done = (w <= 0) || (t >= b);
  endfunction

  // Advance the walk by one pixel; emits is set when a byte write results
  function automatic void blit_pixel(input logic [7:0] p, output bit used, output bit emits,
                                     output fb_write_t wr_out);
    int          l, t, b, wd;
    int unsigned row_len, addr;
    logic [7:0]  data;
    used   = !walk_done;
    emits  = 1'b0;
    wr_out = '0;
    if (walk_done) return;
    clip_rect(l, t, b, wd);
    if (sh_mode == MODE_PALETTE) begin
      row_len = wd;
      data    = 8'((32'(p) * PAL_COUNT) / 256 + PAL_BASE);
      addr    = 32'(walk_row) * 32'(sh_lb) + l + 32'(walk_col);
      emits   = 1'b1;
    end else begin
      // pack MSB first, one byte per eight pixels
      row_len  = (wd + 7) & ~7;
      mono_acc = {mono_acc[6:0], p > MONO_THRESHOLD};
      data     = mono_acc;
      addr     = 32'(walk_row) * 32'(sh_lb) + l / 8 + 32'(walk_col) / 8;
      mono_cnt = mono_cnt + 3'd1;
      if (mono_cnt == 3'd0) begin
        emits    = 1'b1;
        mono_acc = '0;
      end
    end
    // advance column, wrap to the next row at the end of a row
    walk_col = walk_col + 1'b1;
    if (walk_col >= row_len) begin
      walk_col = '0;
      mono_cnt = '0;
      mono_acc = '0;
      walk_row = walk_row + 1'b1;
      if (walk_row >= b) walk_done = 1'b1;
    end
    wr_out.addr = addr[ADDR_W-1:0];
    wr_out.data = data;
    wr_out.last = walk_done;
  endfunction

  // ---------------------------------------------------------------- drivers

  // APB write: setup cycle, access cycle, then back to idle
  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_MODE:       sh_mode   = v[0];
      REG_FRAME_W:    sh_fw     = v[DIM_W-1:0];
      REG_FRAME_H:    sh_fh     = v[DIM_W-1:0];
      REG_LINE_BYTES: sh_lb     = v[LB_W-1:0];
      REG_LEFT:       sh_left   = v[COORD_W-1:0];
      REG_BOTTOM:     sh_bottom = v[COORD_W-1:0];
      REG_WIDTH:      sh_w      = v[DIM_W-1:0];
      REG_HEIGHT:     sh_h      = v[DIM_W-1:0];
      default: ;
    endcase
    restart_walk();
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one pixel item, predict on acceptance
  task automatic send_pixel(input logic [7:0] p, input bit fixed_on, input fb_write_t fixed,
                            output bit used);
    bit        emits;
    fb_write_t predicted;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    do @(posedge clk); while (!in_tready);
    blit_pixel(p, used, emits, predicted);
    if (fixed_on) pending_writes.push_back(fixed);
    else if (emits) pending_writes.push_back(predicted);
    @(negedge clk);
  endtask

  // Drop valid, wait for all expected writes, then let the pipeline empty
  task automatic settle_block();
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int reg_bits(input reg_idx_t r);
    case (r)
      REG_MODE:                 return 1;
      REG_LINE_BYTES:           return LB_W;
      REG_LEFT, REG_BOTTOM:     return COORD_W;
      default:                  return DIM_W;
    endcase
  endfunction

  function automatic logic [31:0] pick_edge(input logic [31:0] lo, input logic [31:0] hi,
                                            input logic [31:0] mask);
    case ($urandom_range(2))
      0:       return lo;
      1:       return hi;
      default: return $urandom & mask;
    endcase
  endfunction

  // One rectangle: new settings, then its pixels (mostly complete, sometimes cut short)
  task automatic run_job(input bit big, output int used_cnt);
    logic [31:0] vals [8];
    logic [31:0] v;
    int          fw, fh, pos, l, t, b, w, n, cnt;
    bit          used;
    settle_block();
    if (big) begin
      vals = '{32'(MODE_PALETTE), 64, 8, 64, 0, 8, 40, 6};
    end else if ($urandom_range(9) == 0) begin
      vals[0] = $urandom_range(1);
      vals[1] = pick_edge(0, 4095, 32'hFFF);
      vals[2] = pick_edge(0, 4095, 32'hFFF);
      vals[3] = pick_edge(0, 16383, 32'h3FFF);
      vals[4] = pick_edge(32'h8000, 32'h7FFF, 32'hFFFF);
      vals[5] = pick_edge(32'h8000, 32'h7FFF, 32'hFFFF);
      vals[6] = pick_edge(0, 4095, 32'hFFF);
      vals[7] = pick_edge(0, 4095, 32'hFFF);
    end else begin
      fw      = $urandom_range(1, 40);
      fh      = $urandom_range(1, 10);
      vals[0] = $urandom_range(1);
      vals[1] = fw;
      vals[2] = fh;
      vals[3] = $urandom_range(0, 16383);
      pos     = int'($urandom_range(0, fw + 12)) - 8;
      vals[4] = 32'(16'(pos));
      pos     = int'($urandom_range(0, fh + 6)) - 2;
      vals[5] = 32'(16'(pos));
      vals[6] = $urandom_range(0, 24);
      vals[7] = $urandom_range(0, 8);
    end
    // write mode always, the rest mostly; junk in unused upper bits half the time
    for (int i = 0; i < 8; i++) begin
      if (big || i == 0 || $urandom_range(3) != 0) begin
        v = vals[i];
        if ($urandom_range(1) == 1) v = v | ($urandom << reg_bits(reg_idx_t'(i)));
        cfg_write(reg_idx_t'(i), v);
      end
    end
    clip_rect(l, t, b, w);
    if (w <= 0 || t >= b) n = 0;
    else n = (b - t) * ((sh_mode == MODE_MONO) ? ((w + 7) & ~7) : w);
    if (n == 0) cnt = $urandom_range(1, 3);
    else if (n > 1 && $urandom_range(9) == 0) cnt = $urandom_range(1, n - 1);
    else cnt = n + $urandom_range(0, 3);
    if (cnt > PIXEL_CAP) cnt = PIXEL_CAP;
    if (big) hold_req = 1'b1;
    used_cnt = 0;
    for (int k = 0; k < cnt; k++) begin
      send_pixel(8'($urandom), 1'b0, '0, used);
      used_cnt += int'(used);
    end
  endtask

  function automatic stim_row_t wr(input reg_idx_t r, input logic [31:0] v);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_WRITE;
    row.idx  = r;
    row.val  = v;
    return row;
  endfunction

  function automatic stim_row_t px(input logic [7:0] p);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_PIXEL;
    row.pix  = p;
    return row;
  endfunction

  function automatic stim_row_t pxw(input logic [7:0] p, input logic [ADDR_W-1:0] a,
                                    input logic [7:0] d, input logic lst);
    stim_row_t row;
    row             = px(p);
    row.fixed_on    = 1'b1;
    row.fixed.addr  = a;
    row.fixed.data  = d;
    row.fixed.last  = lst;
    return row;
  endfunction

  // ---------------------------------------------------------------- receiver side

  // Drive ready at random, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Check each accepted byte write against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected byte write: byte_addr %0d byte_data %0d", out_tdata[ADDR_W-1:0],
               out_tdata[ADDR_W+7:ADDR_W]);
        errors++;
      end else begin
        head_write = pending_writes.pop_front();
        if (out_tdata[ADDR_W-1:0] !== head_write.addr) begin
          $error("byte_addr: expected %0d, got %0d", head_write.addr, out_tdata[ADDR_W-1:0]);
          errors++;
        end
        if (out_tdata[ADDR_W+7:ADDR_W] !== head_write.data) begin
          $error("byte_data: expected %0d, got %0d", head_write.data,
                 out_tdata[ADDR_W+7:ADDR_W]);
          errors++;
        end
        if (out_tlast !== head_write.last) begin
          $error("last: expected %0d, got %0d", head_write.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("gray_image_rect_blit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    int  phase_items, job_items;
    bit  used;
    bit  first_job;
    sh_mode   = MODE_PALETTE;
    sh_fw     = '0;
    sh_fh     = '0;
    sh_lb     = '0;
    sh_left   = '0;
    sh_bottom = '0;
    sh_w      = '0;
    sh_h      = '0;
    restart_walk();

    dir_rows = '{
      // empty rectangle after reset: pixel ignored
      px(8'hA5),
      // palette, left edge clipped at column zero, rows 1 and 2
      wr(REG_MODE, 32'(MODE_PALETTE)), wr(REG_FRAME_W, 10), wr(REG_FRAME_H, 6),
      wr(REG_LINE_BYTES, 16), wr(REG_LEFT, 32'h0000_FFFF), wr(REG_BOTTOM, 3),
      wr(REG_WIDTH, 4), wr(REG_HEIGHT, 2),
      pxw(8'd0, 16, 8'd32, 1'b0), pxw(8'd255, 17, 8'd247, 1'b0), px(8'd127),
      px(8'd128), px(8'd1), pxw(8'd200, 34, 8'd200, 1'b1),
      // past the end of the rectangle: ignored
      px(8'd77),
      // one-bit, rectangle inside the frame, padding pixels still consumed
      wr(REG_MODE, 32'(MODE_MONO)), wr(REG_FRAME_W, 20), wr(REG_LEFT, 9),
      wr(REG_WIDTH, 10), wr(REG_BOTTOM, 1), wr(REG_HEIGHT, 1),
      px(8'd255), px(8'd0), px(8'd128), px(8'd127), px(8'd255), px(8'd255), px(8'd0),
      pxw(8'd0, 1, 8'hAC, 1'b0),
      px(8'd255), px(8'd255), px(8'd0), px(8'd200), px(8'd0), px(8'd0), px(8'd0),
      pxw(8'd0, 2, 8'hD0, 1'b1)
    };

    // hold reset, then release it
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    snd_idle_pct = 25;
    rcv_idle_pct = 63;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        settle_block();
        cfg_write(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_pixel(dir_rows[i].pix, dir_rows[i].fixed_on, dir_rows[i].fixed, used);
      end
    end

    // random rectangles under three idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 25; rcv_idle_pct = 63; end
        1: begin snd_idle_pct = 63; rcv_idle_pct = 25; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      phase_items = 0;
      first_job   = 1'b1;
      while (phase_items < PHASE_ITEMS) begin
        run_job(ph == 0 && first_job, job_items);
        phase_items += job_items;
        first_job = 1'b0;
      end
    end

    settle_block();
    if (errors == 0 && pending_writes.size() == 0) begin
      $display("gray_image_rect_blit verification clean");
    end else begin
      $display("gray_image_rect_blit verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/girb_pkg.sv
hw/rtl/girb_walk.sv
hw/rtl/gray_image_rect_blit.sv
hw/rtl/girb_checker.sv
tb/gray_image_rect_blit_test.sv
